>>> rtl/core/pbr_pkg.sv
// Shared types and constants for the pulse beat-rate detector.
package pbr_pkg;

  // Fixed field widths.
  localparam int unsigned FloorW  = 12;
  localparam int unsigned TickW   = 16;
  localparam int unsigned RateW   = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Register reset values.
  localparam logic [FloorW-1:0] TroughFloorRst = 12'd1500;
  localparam logic [TickW-1:0]  BlinkPeriodRst = 16'd750;
  localparam logic [TickW-1:0]  RateNumRst     = 16'd6000;

  // The rate divider retires one quotient bit per step.
  localparam int unsigned DivSteps = TickW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TROUGH_FLOOR = 2'd0,
    CFG_BLINK_PERIOD = 2'd1,
    CFG_RATE_NUM     = 2'd2
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic out_load;
  } pbr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } pbr_stat_t;

endpackage

>>> rtl/core/pbr_if.sv
// Channel interfaces for sample words, result words and register writes.
interface pbr_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pbr_out_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                     valid;
  logic                     ready;
  logic [pbr_pkg::RateW-1:0] beat_rate;
  logic                     armed;
  logic [SAMPLE_BITS-1:0]   sample_echo;
  logic                     beat_led;
  logic                     blink_led;

  modport source (output valid, output beat_rate, output armed, output sample_echo,
                  output beat_led, output blink_led, input ready);
  modport sink   (input valid, input beat_rate, input armed, input sample_echo,
                  input beat_led, input blink_led, output ready);
endinterface

interface pbr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pbr_pkg::CfgIdxW-1:0] index;
  logic [pbr_pkg::CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pbr_datapath.sv
// Datapath: detector state, configuration registers, rate divider and result registers.
module pbr_datapath #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pbr_pkg::pbr_cmd_t               cmd_i,
  output pbr_pkg::pbr_stat_t              stat_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic                            cfg_we_i,
  input  logic [pbr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pbr_pkg::CfgDatW-1:0]     cfg_data_i,
  output logic [pbr_pkg::RateW-1:0]       beat_rate_o,
  output logic                            armed_o,
  output logic [SAMPLE_BITS-1:0]          sample_echo_o,
  output logic                            beat_led_o,
  output logic                            blink_led_o
);
  import pbr_pkg::*;

  localparam int unsigned CmpW  = TickW + 1;
  localparam int unsigned DvsrW = TickW + 1;

  // Configuration registers.
  logic [FloorW-1:0] floor_q;
  logic [TickW-1:0]  period_q, num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= TroughFloorRst;
      period_q <= BlinkPeriodRst;
      num_q    <= RateNumRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TROUGH_FLOOR: floor_q  <= cfg_data_i[FloorW-1:0];
        CFG_BLINK_PERIOD: period_q <= cfg_data_i[TickW-1:0];
        CFG_RATE_NUM:     num_q    <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Detector state.
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [SAMPLE_BITS:0]   trough_q, trough_d;
  logic                   armed_q, armed_d;
  logic [TickW-1:0]       elapsed_q, elapsed_d, elapsed_inc;
  logic [TickW-1:0]       interval_q, interval_d;
  logic [TickW-1:0]       blink_cnt_q, blink_cnt_d;
  logic                   beat_q, beat_d;
  logic                   blink_q, blink_d;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS:0]   mid_sum;
  logic [SAMPLE_BITS-1:0] mid;
  logic [CmpW-1:0]        samp_w, floor_w;
  logic                   rise, fall;

  // Next detector state for the incoming word.
  always_comb begin
    samp_w  = CmpW'(sample_i);
    floor_w = CmpW'(floor_q);

    // Blink divider runs first within a tick.
    blink_d = blink_q;
    if (blink_cnt_q >= period_q) begin
      blink_d     = ~blink_q;
      blink_cnt_d = TickW'(1);
    end else begin
      blink_cnt_d = blink_cnt_q + TickW'(1);
    end

    // Running extremes; the trough only follows samples above the floor.
    peak_d   = (sample_i > peak_q) ? sample_i : peak_q;
    trough_d = (({1'b0, sample_i} < trough_q) && (samp_w > floor_w)) ?
               {1'b0, sample_i} : trough_q;
    mid_sum  = {1'b0, peak_d} + trough_d;
    mid      = mid_sum[SAMPLE_BITS:1];

    // Tick counter saturates at its maximum.
    elapsed_inc = (elapsed_q != '1) ? elapsed_q + TickW'(1) : elapsed_q;

    rise = (sample_i >= mid) && armed_q;
    fall = (sample_i < mid) && !armed_q;

    armed_d    = armed_q;
    beat_d     = beat_q;
    interval_d = interval_q;
    elapsed_d  = elapsed_inc;
    if (rise) begin
      armed_d    = 1'b0;
      beat_d     = ~beat_q;
      interval_d = elapsed_inc;
    end
    if (fall) begin
      armed_d   = 1'b1;
      beat_d    = ~beat_q;
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      trough_q    <= {1'b1, {SAMPLE_BITS{1'b0}}};
      armed_q     <= 1'b1;
      elapsed_q   <= '0;
      interval_q  <= '0;
      blink_cnt_q <= '0;
      beat_q      <= 1'b0;
      blink_q     <= 1'b0;
    end else if (cmd_i.accept) begin
      peak_q      <= peak_d;
      trough_q    <= trough_d;
      armed_q     <= armed_d;
      elapsed_q   <= elapsed_d;
      interval_q  <= interval_d;
      blink_cnt_q <= blink_cnt_d;
      beat_q      <= beat_d;
      blink_q     <= blink_d;
    end
  end

  // The sample is held for the echo field.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
    end
  end

  // Restoring divider: numerator over twice the interval, one bit per step.
  logic [DvsrW-1:0]   rem_q, rem_d;
  logic [TickW-1:0]   dq_q, dq_d;
  logic [DvsrW-1:0]   dvsr_q;
  logic               zero_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DvsrW:0]     shifted, diff;
  logic               ge;

  always_comb begin
    shifted = {rem_q, dq_q[TickW-1]};
    diff    = shifted - {1'b0, dvsr_q};
    ge      = shifted >= {1'b0, dvsr_q};
    rem_d   = ge ? diff[DvsrW-1:0] : shifted[DvsrW-1:0];
    dq_d    = {dq_q[TickW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      dq_q   <= num_q;
      dvsr_q <= {interval_q, 1'b0};
      zero_q <= (interval_q == '0);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign stat_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Result registers hold the word until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      beat_rate_o   <= zero_q ? '0 : dq_q[RateW-1:0];
      armed_o       <= armed_q;
      sample_echo_o <= sample_q;
      beat_led_o    <= beat_q;
      blink_led_o   <= blink_q;
    end
  end

endmodule

>>> rtl/core/pbr_ctrl.sv
// Controller: sequences accept, divider steps and result delivery.
module pbr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pbr_pkg::pbr_cmd_t  cmd_o,
  input  pbr_pkg::pbr_stat_t stat_i
);
  import pbr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVIDE,
    ST_DELIVER
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Commands decode from the current state.
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.accept    = in_valid_i && in_ready_o;
    cmd_o.div_init  = (state_q == ST_PREP);
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.out_load  = (state_q == ST_DELIVER) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  // State and the result-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept) state_q <= ST_PREP;
        end
        ST_PREP: begin
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (stat_i.div_last) state_q <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (cmd_o.out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/pulse_beat_rate_detector.sv
// Top level of the pulse beat-rate detector.
// A sample word is accepted in ST_IDLE; ST_PREP loads the divider, ST_DIVIDE runs
// the 16-step rate divider and ST_DELIVER loads the result word, which can stall
// on the sink. A new sample word is taken only after its result is loaded.
// Reset (rst_ni low, asynchronous) clears the detector state and restores
// the register defaults; no clearing pass is needed.
module pulse_beat_rate_detector #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbr_in_if.sink    in_i,
  pbr_out_if.source out_o,
  pbr_cfg_if.sink   cfg_i
);
  import pbr_pkg::*;

  pbr_cmd_t  cmd;
  pbr_stat_t stat;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  pbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  pbr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .sample_i      (in_i.sample),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .beat_rate_o   (out_o.beat_rate),
    .armed_o       (out_o.armed),
    .sample_echo_o (out_o.sample_echo),
    .beat_led_o    (out_o.beat_led),
    .blink_led_o   (out_o.blink_led)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the pulse beat-rate detector.
module testbench;
  import pbr_pkg::*;

  localparam int unsigned SampleBits    = 12;
  localparam int unsigned ResultLatency = 18;
  localparam int unsigned SettleCycles  = 2 * ResultLatency;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandPhases    = 6;
  localparam int unsigned PhaseItems    = 62;
  localparam int unsigned TimeLimit     = 2000000;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef struct packed {
    logic [RateW-1:0]      beat_rate;
    logic                  armed;
    logic [SampleBits-1:0] sample_echo;
    logic                  beat_led;
    logic                  blink_led;
  } beat_result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } reg_write_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side copies of every block input, known from time zero.
  logic                  src_valid  = 1'b0;
  logic [SampleBits-1:0] src_sample = '0;
  logic                  snk_ready  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index  = '0;
  logic [CfgDatW-1:0]    cfg_data   = '0;

  // Handshakes seen at the last rising edge.
  logic sample_fire = 1'b0;
  logic cfg_fire    = 1'b0;

  logic idling_on    = 1'b1;
  logic rx_hold      = 1'b0;
  logic stress_phase = 1'b0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;

  logic [SampleBits-1:0] sample_queue[$];
  reg_write_t            cfg_queue[$];
  beat_result_t          pending_results[$];

  int unsigned err_count       = 0;
  int unsigned samples_sent    = 0;
  int unsigned writes_done     = 0;
  int unsigned results_checked = 0;

  // Register shadow copies.
  logic [FloorW-1:0] floor_cfg = TroughFloorRst;
  logic [TickW-1:0]  blink_cfg = BlinkPeriodRst;
  logic [TickW-1:0]  num_cfg   = RateNumRst;

  // Detector shadow state.
  logic [SampleBits-1:0] peak_q      = '0;
  logic [SampleBits:0]   trough_q    = {1'b1, {SampleBits{1'b0}}};
  logic                  armed_q     = 1'b1;
  logic [TickW-1:0]      elapsed_q   = '0;
  logic [TickW-1:0]      interval_q  = '0;
  logic [TickW-1:0]      blink_cnt_q = '0;
  logic                  beat_led_q  = 1'b0;
  logic                  blink_led_q = 1'b0;

  pbr_in_if  #(.SAMPLE_BITS(SampleBits)) sample_ch ();
  pbr_out_if #(.SAMPLE_BITS(SampleBits)) result_ch ();
  pbr_cfg_if                             cfg_ch ();

  assign sample_ch.valid  = src_valid;
  assign sample_ch.sample = src_sample;
  assign result_ch.ready  = snk_ready;
  assign cfg_ch.valid     = cfg_valid;
  assign cfg_ch.index     = cfg_index;
  assign cfg_ch.data      = cfg_data;

  pulse_beat_rate_detector #(
    .SAMPLE_BITS(SampleBits)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (sample_ch),
    .out_o (result_ch),
    .cfg_i (cfg_ch)
  );

  always #5 clk = ~clk;

  // Hold reset, then release it away from the rising edge.
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Advance the shadow detector by one tick and return the result word it gives.
  function automatic beat_result_t predict_beat(input logic [SampleBits-1:0] s);
    beat_result_t r;
    int unsigned  pk;
    int unsigned  tr;
    int unsigned  mid;
    int unsigned  rate;
    // The blink divider runs ahead of the detector.
    if (blink_cnt_q >= blink_cfg) begin
      blink_led_q = ~blink_led_q;
      blink_cnt_q = '0;
    end
    blink_cnt_q = blink_cnt_q + TickW'(1);

    if (s > peak_q) peak_q = s;
    if ({1'b0, s} < trough_q && s > floor_cfg) trough_q = {1'b0, s};
    pk  = peak_q;
    tr  = trough_q;
    mid = (pk + tr) >> 1;

    if (elapsed_q != {TickW{1'b1}}) elapsed_q = elapsed_q + TickW'(1);

    if (s >= mid && armed_q) begin
      armed_q    = 1'b0;
      beat_led_q = ~beat_led_q;
      interval_q = elapsed_q;
    end
    if (s < mid && !armed_q) begin
      armed_q    = 1'b1;
      elapsed_q  = '0;
      beat_led_q = ~beat_led_q;
    end

    rate = 0;
    if (interval_q != 0) rate = num_cfg / (2 * int'(interval_q));

    r.beat_rate   = rate[RateW-1:0];
    r.armed       = armed_q;
    r.sample_echo = s;
    r.beat_led    = beat_led_q;
    r.blink_led   = blink_led_q;
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      err_count++;
    end
  endfunction

  // Sample driver: offers queued words, with random gaps between them if idling_on.
  always @(negedge clk) begin : sample_driver
    if (rst_n) begin
      if (!src_valid || sample_fire) begin
        if (src_gap != 0) begin
          src_valid <= 1'b0;
          src_gap   <= src_gap - 1;
        end else if (sample_queue.size() != 0) begin
          if (idling_on && $urandom_range(0, 3) == 0) begin
            src_valid <= 1'b0;
            src_gap   <= $urandom_range(1, 16) - 1;
          end else begin
            src_valid  <= 1'b1;
            src_sample <= sample_queue.pop_front();
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random stall bursts if idling_on; stalls fully in a hold-off.
  always @(negedge clk) begin : result_sink
    if (rx_hold) begin
      snk_ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_ready <= 1'b0;
      snk_gap   <= snk_gap - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      snk_ready <= 1'b0;
      snk_gap   <= $urandom_range(1, 16) - 1;
    end else begin
      snk_ready <= 1'b1;
    end
  end

  // Register write driver.
  always @(negedge clk) begin : cfg_driver
    reg_write_t w;
    if (rst_n) begin
      if (!cfg_valid || cfg_fire) begin
        if (cfg_queue.size() != 0) begin
          w = cfg_queue.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.index;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result words, then predicts from accepted samples and writes.
  always @(posedge clk) begin : monitor
    beat_result_t want;
    if (rst_n) begin
      sample_fire <= sample_ch.valid && sample_ch.ready;
      cfg_fire    <= cfg_ch.valid && cfg_ch.ready;

      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no expected entry: sample_echo %0d",
                 result_ch.sample_echo);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("beat_rate", want.beat_rate, result_ch.beat_rate);
          check_field("armed", want.armed, result_ch.armed);
          check_field("sample_echo", want.sample_echo, result_ch.sample_echo);
          check_field("beat_led", want.beat_led, result_ch.beat_led);
          check_field("blink_led", want.blink_led, result_ch.blink_led);
          results_checked++;
        end
      end

      if (sample_ch.valid && sample_ch.ready) begin
        pending_results.push_back(predict_beat(sample_ch.sample));
        samples_sent++;
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TROUGH_FLOOR: floor_cfg = cfg_ch.data[FloorW-1:0];
          CFG_BLINK_PERIOD: blink_cfg = cfg_ch.data[TickW-1:0];
          CFG_RATE_NUM:     num_cfg   = cfg_ch.data[TickW-1:0];
          default: ;
        endcase
        writes_done++;
      end
    end
  end

  // Long output hold-off early in the stress phase, so the block backs up.
  initial begin : output_hold
    wait (stress_phase);
    repeat (8) @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #(TimeLimit);
    $display("Verification failed");
    $finish;
  end

  // Wait until every queued word is through and every result has come back.
  // The check runs at the rising edge, where the drivers' outputs are settled.
  task automatic wait_until_idle();
    while (sample_queue.size() != 0 || src_valid || pending_results.size() != 0 ||
           cfg_queue.size() != 0 || cfg_valid)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    reg_write_t w;
    w.index = idx;
    w.data  = data;
    cfg_queue.push_back(w);
  endtask

  task automatic apply_settings(input logic [CfgDatW-1:0] floor_v,
                                input logic [CfgDatW-1:0] blink_v,
                                input logic [CfgDatW-1:0] num_v);
    write_reg(CFG_TROUGH_FLOOR, floor_v);
    write_reg(CFG_BLINK_PERIOD, blink_v);
    write_reg(CFG_RATE_NUM, num_v);
    wait_until_idle();
  endtask

  // Mostly beat-shaped runs (high plateau, low valley) with some raw noise mixed in.
  task automatic queue_pulse_train(input int unsigned count);
    int unsigned left;
    int unsigned run;
    int unsigned k;
    left = count;
    while (left != 0) begin
      if ($urandom_range(0, 3) == 0) begin
        run = $urandom_range(1, 5);
        for (k = 0; k < run && left != 0; k++) begin
          sample_queue.push_back(SampleBits'($urandom_range(0, 4095)));
          left--;
        end
      end else begin
        run = $urandom_range(1, 6);
        for (k = 0; k < run && left != 0; k++) begin
          sample_queue.push_back(SampleBits'($urandom_range(2400, 4095)));
          left--;
        end
        run = $urandom_range(1, 24);
        for (k = 0; k < run && left != 0; k++) begin
          sample_queue.push_back(SampleBits'($urandom_range(0, 1800)));
          left--;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [SampleBits-1:0] reset_set [12] = '{12'd0, 12'd4095, 12'd0, 12'd1500, 12'd1501,
                                              12'd4095, 12'd100, 12'd100, 12'd3000,
                                              12'd200, 12'd2500, 12'd0};
    logic [SampleBits-1:0] swing_set [4]  = '{12'd1, 12'd4095, 12'd1, 12'd4095};
    logic [SampleBits-1:0] flip_set [4]   = '{12'd4095, 12'd0, 12'd4095, 12'd0};
    logic [SampleBits-1:0] beat_set [5]   = '{12'd3000, 12'd100, 12'd3000, 12'd100,
                                              12'd3000};
    logic [SampleBits-1:0] short_set [3]  = '{12'd100, 12'd3000, 12'd100};
    int unsigned phase;

    @(posedge rst_n);
    @(posedge clk);

    // Register defaults straight out of reset, across floor and full-scale samples.
    foreach (reset_set[k]) sample_queue.push_back(reset_set[k]);
    wait_until_idle();

    // Upper data bits dropped, blink on every tick, zero numerator, unused index.
    write_reg(CFG_TROUGH_FLOOR, 16'hF000);
    write_reg(CFG_BLINK_PERIOD, 16'd0);
    write_reg(CFG_RATE_NUM, 16'd0);
    write_reg(CfgIdxUnused, 16'hFFFF);
    wait_until_idle();
    foreach (swing_set[k]) sample_queue.push_back(swing_set[k]);
    wait_until_idle();

    // Numerator of one, longest blink period, highest floor.
    apply_settings(16'hFFFF, 16'hFFFF, 16'd1);
    foreach (flip_set[k]) sample_queue.push_back(flip_set[k]);
    wait_until_idle();

    // Let the blink count grow, then drop the period below it.
    apply_settings(16'd1500, 16'd750, 16'd6000);
    foreach (beat_set[k]) sample_queue.push_back(beat_set[k]);
    wait_until_idle();
    write_reg(CFG_BLINK_PERIOD, 16'd2);
    wait_until_idle();
    foreach (short_set[k]) sample_queue.push_back(short_set[k]);
    wait_until_idle();

    // Random beat trains under a new setting in each phase.
    for (phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        1: apply_settings(16'd0, 16'd1, 16'hFFFF);
        2: apply_settings(16'd4095, 16'hFFFF, 16'd2);
        4: apply_settings(CfgDatW'($urandom_range(0, 4095)), CfgDatW'($urandom_range(1, 12)),
                          16'd65534);
        default: apply_settings(CfgDatW'($urandom_range(0, 4095)),
                                CfgDatW'($urandom_range(1, 12)),
                                CfgDatW'($urandom_range(2, 65534)));
      endcase
      if (phase == 1) stress_phase = 1'b1;
      if (phase == RandPhases - 1) idling_on = 1'b0;
      if (phase == 3) begin
        // Sender stops halfway until the block has fully drained.
        queue_pulse_train(PhaseItems / 2);
        wait_until_idle();
        queue_pulse_train(PhaseItems - PhaseItems / 2);
      end else begin
        queue_pulse_train(PhaseItems);
      end
      wait_until_idle();
    end

    $display("Sent %0d sample words and %0d register writes; checked %0d result words.",
             samples_sent, writes_done, results_checked);
    $display("Covered register extremes, an unused index, a long output stall and a drain.");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pbr_pkg.sv
rtl/core/pbr_if.sv
rtl/core/pbr_datapath.sv
rtl/core/pbr_ctrl.sv
rtl/core/pulse_beat_rate_detector.sv
verif/testbench.sv
